// ===== rtl/lookup3_byte_key_hash_unit_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the lookup3 byte key hash unit.
// Each macro expands to one labelled concurrent assertion on the rising edge
// of the given clock, disabled while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef LOOKUP3_BYTE_KEY_HASH_UNIT_ASSERT_SVH
`define LOOKUP3_BYTE_KEY_HASH_UNIT_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons holds at that edge.
`define L3H_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("lookup3 hash unit: assertion failed");

// Next-cycle implication: whenever ante holds, cons holds at the next edge.
`define L3H_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("lookup3 hash unit: assertion failed");

`endif

// ===== rtl/l3h_pkg.sv =====
// ---------------------------------------------------------------------------
// l3h_pkg
// Types, constants and round functions shared by the lookup3 hash unit.
// ---------------------------------------------------------------------------
package l3h_pkg;

	// Seed constant of the lookup3 scheme and block size in bytes.
	localparam logic [31:0] SEED_CONST  = 32'hdeadbeef;
	localparam int          BLOCK_BYTES = 12;

	// Field widths.
	localparam int WORD_W    = 32;
	localparam int VB_W      = 3;
	localparam int KEY_LEN_W = 16;
	localparam int CFG_IDX_W = 2;

	// Depth of the queue between the front and back parts.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Rounds of the block mix and of the final mix.
	localparam int MIX_STEPS  = 6;
	localparam int FIN_STAGES = 7;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INITIAL_VALUE = 2'd0,
		REG_SLOT_MASK     = 2'd1
	} cfg_reg_t;

	// Back part sequencer states.
	typedef enum logic [1:0] {
		ST_ADD,
		ST_MIX,
		ST_POST
	} back_state_t;

	// The three lookup3 working words.
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
	} abc_t;

	// One decoded item as handed from the front part to the back part.
	// pre_add is the little-endian block addend summed before any mix,
	// post_add the addend for word a of the next block, after the mix.
	typedef struct packed {
		logic        seed_en;
		logic [31:0] seed;
		logic [95:0] pre_add;
		logic        mix_en;
		logic [31:0] post_add;
		logic        last;
		logic        empty;
	} op_t;

	// Left rotation by a constant amount between 1 and 31.
	function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] r);
		return (x << r) | (x >> (6'd32 - {1'b0, r}));
	endfunction

	// One line of the lookup3 block mix.
	function automatic abc_t mix_step(input logic [2:0] idx, input abc_t s);
		abc_t o;
		o = s;
		case (idx)
			3'd0: begin o.a = (s.a - s.c) ^ rotl(s.c, 5'd4);  o.c = s.c + s.b; end
			3'd1: begin o.b = (s.b - s.a) ^ rotl(s.a, 5'd6);  o.a = s.a + s.c; end
			3'd2: begin o.c = (s.c - s.b) ^ rotl(s.b, 5'd8);  o.b = s.b + s.a; end
			3'd3: begin o.a = (s.a - s.c) ^ rotl(s.c, 5'd16); o.c = s.c + s.b; end
			3'd4: begin o.b = (s.b - s.a) ^ rotl(s.a, 5'd19); o.a = s.a + s.c; end
			3'd5: begin o.c = (s.c - s.b) ^ rotl(s.b, 5'd4);  o.b = s.b + s.a; end
			default: o = s;
		endcase
		return o;
	endfunction

	// One line of the lookup3 final mix.
	function automatic abc_t fin_step(input logic [2:0] idx, input abc_t s);
		abc_t o;
		o = s;
		case (idx)
			3'd0: o.c = (s.c ^ s.b) - rotl(s.b, 5'd14);
			3'd1: o.a = (s.a ^ s.c) - rotl(s.c, 5'd11);
			3'd2: o.b = (s.b ^ s.a) - rotl(s.a, 5'd25);
			3'd3: o.c = (s.c ^ s.b) - rotl(s.b, 5'd16);
			3'd4: o.a = (s.a ^ s.c) - rotl(s.c, 5'd4);
			3'd5: o.b = (s.b ^ s.a) - rotl(s.a, 5'd14);
			3'd6: o.c = (s.c ^ s.b) - rotl(s.b, 5'd24);
			default: o = s;
		endcase
		return o;
	endfunction

endpackage

// ===== rtl/l3h_if.sv =====
// ---------------------------------------------------------------------------
// l3h interfaces
// Valid/ready channels of the lookup3 hash unit: key words in, hash values
// out, and configuration register writes.
// ---------------------------------------------------------------------------

// Key word channel.
interface l3h_key_if import l3h_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [WORD_W-1:0]    key_word;
	logic [VB_W-1:0]      valid_bytes;
	logic                 first_item;
	logic                 last_item;
	logic [KEY_LEN_W-1:0] key_length;

	modport source (output valid, key_word, valid_bytes, first_item, last_item, key_length,
		input ready);
	modport sink (input valid, key_word, valid_bytes, first_item, last_item, key_length,
		output ready);
endinterface

// Hash result channel.
interface l3h_hash_if import l3h_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] hash_value;

	modport source (output valid, hash_value, input ready);
	modport sink (input valid, hash_value, output ready);
endinterface

// Configuration write channel.
interface l3h_cfg_if import l3h_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] reg_index;
	logic [WORD_W-1:0]    wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/l3h_front.sv =====
// ---------------------------------------------------------------------------
// l3h_front
// Accepts key words, tracks the byte position within the current block and
// turns each word into block addends, a mix request and end-of-key flags.
// ---------------------------------------------------------------------------
module l3h_front import l3h_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	l3h_key_if.sink     key_in,
	input  logic [31:0] initial_value,
	output logic        op_valid,
	output op_t         op,
	input  logic        op_ready
);

	logic [3:0]   cnt_q;
	logic [2:0]   nbytes;
	logic [3:0]   base;
	logic [3:0]   pos;
	logic [127:0] ext;
	logic [4:0]   sum;
	logic [4:0]   new_cnt;
	logic         mix_en;
	logic         accept;

	// The front part passes stalls straight through from the queue.
	assign key_in.ready = op_ready;
	assign op_valid     = key_in.valid;
	assign accept       = key_in.valid && op_ready;

	// Place each valid byte at its position within the block and the next one.
	always_comb begin
		nbytes = (key_in.valid_bytes > 3'd4) ? 3'd4 : key_in.valid_bytes;
		base   = key_in.first_item ? 4'd0 : cnt_q;
		ext    = '0;
		pos    = base;
		for (int i = 0; i < 4; i++) begin
			pos = base + 4'(i);
			if (3'(i) < nbytes) begin
				ext = ext | (128'(key_in.key_word[8*i +: 8]) << {pos, 3'b000});
			end
		end
		sum     = {1'b0, base} + {2'b00, nbytes};
		mix_en  = sum > 5'(BLOCK_BYTES);
		new_cnt = mix_en ? (sum - 5'(BLOCK_BYTES)) : sum;
	end

	// Decoded item.
	always_comb begin
		op.seed_en  = key_in.first_item;
		op.seed     = SEED_CONST + 32'(key_in.key_length) + initial_value;
		op.pre_add  = ext[95:0];
		op.mix_en   = mix_en;
		op.post_add = ext[127:96];
		op.last     = key_in.last_item;
		op.empty    = new_cnt == 5'd0;
	end

	// Byte count of the current block; twelve means a full block awaits its mix.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= new_cnt[3:0];
		end
	end

endmodule

// ===== rtl/l3h_queue.sv =====
// ---------------------------------------------------------------------------
// l3h_queue
// Short first-in first-out queue of decoded items between the front and
// back parts.
// ---------------------------------------------------------------------------
module l3h_queue import l3h_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  op_t  push_op,
	output logic pop_valid,
	input  logic pop_ready,
	output op_t  pop_op
);

	op_t                mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               push;
	logic               pop;

	assign push_ready = cnt_q != Q_CNT_W'(Q_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_op     = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

endmodule

// ===== rtl/l3h_back.sv =====
// ---------------------------------------------------------------------------
// l3h_back
// Holds the lookup3 words a, b and c, sums decoded addends into them, runs
// the block mix one line per cycle and hands finished keys to the final mix.
// ---------------------------------------------------------------------------
`include "lookup3_byte_key_hash_unit_assert.svh"

module l3h_back import l3h_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic op_valid,
	output logic op_ready,
	input  op_t  op,
	output logic fin_valid,
	input  logic fin_ready,
	output abc_t fin_abc,
	output logic fin_empty
);

	localparam logic [2:0] MIX_LAST = 3'(MIX_STEPS - 1);

	back_state_t state_q;
	back_state_t state_d;
	logic [2:0]  step_q;
	abc_t        s_q;
	logic [31:0] post_add_q;
	logic        last_q;
	logic        empty_q;
	abc_t        base;
	abc_t        added;
	abc_t        posted;
	logic        emit_now;
	logic        pop;

	// Seed or present state plus the addend of the bytes before any mix.
	always_comb begin
		base    = op.seed_en ? abc_t'{a: op.seed, b: op.seed, c: op.seed} : s_q;
		added.a = base.a + op.pre_add[31:0];
		added.b = base.b + op.pre_add[63:32];
		added.c = base.c + op.pre_add[95:64];
		posted   = s_q;
		posted.a = s_q.a + post_add_q;
	end

	// Sequencer: next state and handshakes.
	always_comb begin
		state_d   = state_q;
		emit_now  = op.last && !op.mix_en;
		op_ready  = 1'b0;
		fin_valid = 1'b0;
		fin_abc   = added;
		fin_empty = op.empty;
		case (state_q)
			ST_ADD: begin
				op_ready  = !emit_now || fin_ready;
				fin_valid = op_valid && emit_now && fin_ready;
				if (op_valid && op_ready && op.mix_en) begin
					state_d = ST_MIX;
				end
			end
			ST_MIX: begin
				if (step_q == MIX_LAST) begin
					state_d = ST_POST;
				end
			end
			ST_POST: begin
				fin_abc   = posted;
				fin_empty = empty_q;
				fin_valid = last_q && fin_ready;
				if (!last_q || fin_ready) begin
					state_d = ST_ADD;
				end
			end
			default: state_d = ST_ADD;
		endcase
	end

	assign pop = op_valid && op_ready;

	// State register and mix round counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ADD;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MIX) begin
				step_q <= (step_q == MIX_LAST) ? 3'd0 : step_q + 3'd1;
			end
		end
	end

	// The working words reset to zero; item fields held across a mix need none.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_q <= '0;
		end else begin
			case (state_q)
				ST_ADD: begin
					if (pop) begin
						s_q <= added;
					end
				end
				ST_MIX: s_q <= mix_step(step_q, s_q);
				ST_POST: begin
					if (!last_q || fin_ready) begin
						s_q <= posted;
					end
				end
				default: s_q <= s_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			post_add_q <= op.post_add;
			last_q     <= op.last;
			empty_q    <= op.empty;
		end
	end

	// Items leave the queue only in the add state.
	`L3H_ASSERT_IMP(a_pop_in_add, clk, arst_n, pop, state_q == ST_ADD)
	// A key is handed on only when the final mix moves.
	`L3H_ASSERT_IMP(a_fin_when_ready, clk, arst_n, fin_valid, fin_ready)
	// The last mix round is always followed by the post-mix addition.
	`L3H_ASSERT_NXT(a_mix_to_post, clk, arst_n,
		state_q == ST_MIX && step_q == MIX_LAST, state_q == ST_POST)

endmodule

// ===== rtl/l3h_final.sv =====
// ---------------------------------------------------------------------------
// l3h_final
// Seven-stage pipeline of the lookup3 final mix, one line per stage, with the
// slot mask applied to the output of the last stage register.
// ---------------------------------------------------------------------------
`include "lookup3_byte_key_hash_unit_assert.svh"

module l3h_final import l3h_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  abc_t        in_abc,
	input  logic        in_empty,
	input  logic [31:0] slot_mask,
	l3h_hash_if.source  hash_out
);

	logic [FIN_STAGES:1] vld_s;
	abc_t                abc_s   [1:FIN_STAGES];
	logic [31:0]         raw_s   [1:FIN_STAGES];
	logic                empty_s [1:FIN_STAGES];
	abc_t                nxt_abc [1:FIN_STAGES];
	logic                adv;

	// The whole pipeline moves whenever its output register is free or taken.
	assign adv      = !vld_s[FIN_STAGES] || hash_out.ready;
	assign in_ready = adv;

	// One final-mix line per stage.
	always_comb begin
		nxt_abc[1] = fin_step(3'd0, in_abc);
		for (int k = 2; k <= FIN_STAGES; k++) begin
			nxt_abc[k] = fin_step(3'(k - 1), abc_s[k-1]);
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[FIN_STAGES-1:1], in_valid};
		end
	end

	// Stage payload; the raw c travels along for an empty key.
	always_ff @(posedge clk) begin
		if (adv) begin
			abc_s[1]   <= nxt_abc[1];
			raw_s[1]   <= in_abc.c;
			empty_s[1] <= in_empty;
			for (int k = 2; k <= FIN_STAGES; k++) begin
				abc_s[k]   <= nxt_abc[k];
				raw_s[k]   <= raw_s[k-1];
				empty_s[k] <= empty_s[k-1];
			end
		end
	end

	// Output: masked hash, or the unmasked seed for a key with no bytes.
	assign hash_out.valid      = vld_s[FIN_STAGES];
	assign hash_out.hash_value = empty_s[FIN_STAGES] ? raw_s[FIN_STAGES]
		: (abc_s[FIN_STAGES].c & slot_mask);

	// A key enters only when the pipeline moves.
	`L3H_ASSERT_IMP(a_enter_on_adv, clk, arst_n, in_valid, adv)
	// While the output stalls, no stage changes occupancy.
	`L3H_ASSERT_NXT(a_hold_on_stall, clk, arst_n, !adv, $stable(vld_s))
	// An occupied first stage moves on to the second when the pipeline moves.
	`L3H_ASSERT_NXT(a_stage_moves, clk, arst_n, adv && vld_s[1], vld_s[2])

endmodule

// ===== rtl/lookup3_byte_key_hash_unit.sv =====
// ---------------------------------------------------------------------------
// lookup3_byte_key_hash_unit
// Streaming little-endian lookup3 hash of byte keys delivered as 32-bit words.
// ---------------------------------------------------------------------------
// Usage:
//   key_in   : one transfer per key word, earliest byte in bits 7..0, with a
//              count of valid bytes; first_item seeds a new key from
//              key_length and initial_value, last_item asks for a result.
//   hash_out : one transfer per item with last_item set, carrying the final
//              hash masked by slot_mask (the unmasked seed for an empty key).
//   cfg      : register writes, index 0 initial_value, 1 slot_mask; always
//              ready, to be used only while no key is in flight.
// Throughput: one key word per cycle while no block mix is due and hash_out
//   is taken. Each 12-byte block mix is run one line per cycle by the back
//   part and holds it for the 6 mix rounds and one post-mix add; a 4-entry
//   queue lets the front part keep taking words meanwhile.
// Path: a last word that needs no mix passes through the queue and the
//   final-mix pipeline; one that completes a block also waits for that mix and its add.
// Reset: clears the working words and byte count to zero, initial_value to
//   zero and slot_mask to all ones; no clearing pass is needed.
// Stall: while hash_out is not taken the final-mix pipeline holds, then the
//   back part, queue and finally key_in.ready drop.
// ---------------------------------------------------------------------------
module lookup3_byte_key_hash_unit import l3h_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	l3h_key_if.sink    key_in,
	l3h_hash_if.source hash_out,
	l3h_cfg_if.sink    cfg
);

	logic [31:0] initial_value_q;
	logic [31:0] slot_mask_q;
	logic        fr_valid;
	logic        fr_ready;
	op_t         fr_op;
	logic        bk_valid;
	logic        bk_ready;
	op_t         bk_op;
	logic        fin_valid;
	logic        fin_ready;
	abc_t        fin_abc;
	logic        fin_empty;

	// Configuration registers.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			initial_value_q <= '0;
			slot_mask_q     <= '1;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.reg_index))
				REG_INITIAL_VALUE: initial_value_q <= cfg.wdata;
				REG_SLOT_MASK:     slot_mask_q     <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// Front part: decodes key words.
	l3h_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.key_in        (key_in),
		.initial_value (initial_value_q),
		.op_valid      (fr_valid),
		.op            (fr_op),
		.op_ready      (fr_ready)
	);

	// Queue between front and back parts.
	l3h_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_op    (fr_op),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_op     (bk_op)
	);

	// Back part: summing and block mix.
	l3h_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (bk_valid),
		.op_ready  (bk_ready),
		.op        (bk_op),
		.fin_valid (fin_valid),
		.fin_ready (fin_ready),
		.fin_abc   (fin_abc),
		.fin_empty (fin_empty)
	);

	// Final mix pipeline and output register.
	l3h_final u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fin_valid),
		.in_ready  (fin_ready),
		.in_abc    (fin_abc),
		.in_empty  (fin_empty),
		.slot_mask (slot_mask_q),
		.hash_out  (hash_out)
	);

endmodule
